### rtl/assert_macros.svh
// Assertion macros for the RTL of the radix digit converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Expression must hold at every clock edge outside reset.
`define RDC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define RDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Antecedent implies consequent in the following cycle.
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define RDC_ASSERT_ALWAYS(lbl, clk, rst_n, expr, msg)
`define RDC_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg)
`define RDC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)

`endif

`endif

### rtl/rdc_pkg.sv
// Types, constants, microcode program and digit alphabet of the radix digit converter.
`default_nettype none

package rdc_pkg;

	localparam int VALUE_WIDTH_DEF = 64;
	localparam int MAX_DIGITS_DEF  = 64;

	localparam int S_TDATA_W = 72;
	localparam int M_TDATA_W = 8;
	localparam int VALUE_W   = 64;
	localparam int BASE_W    = 6;
	localparam int DIGIT_W   = 6;
	localparam int CHAR_W    = 8;
	localparam int STEP_W    = 4;

	localparam logic [BASE_W-1:0] BASE_MIN = 6'd2;
	localparam logic [BASE_W-1:0] BASE_MAX = 6'd62;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UC_A = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_LC_A = 8'h61;

	typedef logic [2:0] rdc_op_t;
	localparam rdc_op_t OP_NONE  = 3'd0;
	localparam rdc_op_t OP_LOAD  = 3'd1;
	localparam rdc_op_t OP_DIV   = 3'd2;
	localparam rdc_op_t OP_STORE = 3'd3;
	localparam rdc_op_t OP_DEC   = 3'd4;
	localparam rdc_op_t OP_EMIT  = 3'd5;
	localparam rdc_op_t OP_ERR   = 3'd6;

	typedef logic [2:0] rdc_cond_t;
	localparam rdc_cond_t COND_NEVER       = 3'd0;
	localparam rdc_cond_t COND_ALWAYS      = 3'd1;
	localparam rdc_cond_t COND_NO_INPUT    = 3'd2;
	localparam rdc_cond_t COND_BAD_BASE    = 3'd3;
	localparam rdc_cond_t COND_DIV_MORE    = 3'd4;
	localparam rdc_cond_t COND_MORE_DIGITS = 3'd5;
	localparam rdc_cond_t COND_OUT_BUSY    = 3'd6;
	localparam rdc_cond_t COND_CNT_NZ      = 3'd7;

	typedef struct packed {
		rdc_op_t            op;
		rdc_cond_t          cond;
		logic [STEP_W-1:0]  target;
	} rdc_uword_t;

	typedef struct packed {
		logic in_valid;
		logic bad_base;
		logic div_more;
		logic more_digits;
		logic out_busy;
		logic cnt_nz;
	} rdc_status_t;

	// Step addresses; all but STEP_LAST are targets that the program jumps to.
	localparam logic [STEP_W-1:0] STEP_LOAD  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_DIV   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_DEC   = 4'd4;
	localparam logic [STEP_W-1:0] STEP_EMIT  = 4'd6;
	localparam logic [STEP_W-1:0] STEP_ERR   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_LAST  = 4'd10;

	// The control program. A taken condition jumps to target, otherwise the
	// step counter advances by one.
	function automatic rdc_uword_t ucode_rom(input logic [STEP_W-1:0] step);
		rdc_uword_t w;
		case (step)
			4'd0:    w = '{op: OP_LOAD,  cond: COND_NO_INPUT,    target: STEP_LOAD};
			4'd1:    w = '{op: OP_NONE,  cond: COND_BAD_BASE,    target: STEP_ERR};
			4'd2:    w = '{op: OP_DIV,   cond: COND_DIV_MORE,    target: STEP_DIV};
			4'd3:    w = '{op: OP_STORE, cond: COND_MORE_DIGITS, target: STEP_DIV};
			4'd4:    w = '{op: OP_DEC,   cond: COND_NEVER,       target: STEP_LOAD};
			4'd5:    w = '{op: OP_NONE,  cond: COND_NEVER,       target: STEP_LOAD};
			4'd6:    w = '{op: OP_EMIT,  cond: COND_OUT_BUSY,    target: STEP_EMIT};
			4'd7:    w = '{op: OP_NONE,  cond: COND_CNT_NZ,      target: STEP_DEC};
			4'd8:    w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: STEP_LOAD};
			4'd9:    w = '{op: OP_ERR,   cond: COND_OUT_BUSY,    target: STEP_ERR};
			4'd10:   w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: STEP_LOAD};
			default: w = '{op: OP_NONE,  cond: COND_ALWAYS,      target: STEP_LOAD};
		endcase
		return w;
	endfunction

	// Maps a digit to its character; the letter ranges swap with lcf.
	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d,
			input logic lcf);
		logic [CHAR_W-1:0] first_a;
		logic [CHAR_W-1:0] second_a;
		logic [CHAR_W-1:0] dx;
		first_a  = lcf ? CHAR_LC_A : CHAR_UC_A;
		second_a = lcf ? CHAR_UC_A : CHAR_LC_A;
		dx       = {2'b00, d};
		if (d < 6'd10) begin
			return CHAR_ZERO + dx;
		end else if (d < 6'd36) begin
			return first_a + dx - 8'd10;
		end else if (d < 6'd62) begin
			return second_a + dx - 8'd36;
		end else begin
			return second_a + dx - 8'd62;
		end
	endfunction

endpackage

`default_nettype wire

### rtl/rdc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module rdc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### rtl/rdc_seq.sv
// Microcode sequencer: step counter, program table and jump condition select.
`default_nettype none

module rdc_seq (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire rdc_pkg::rdc_status_t status,
	output      rdc_pkg::rdc_op_t    op
);

	logic [rdc_pkg::STEP_W-1:0] step_q;
	rdc_pkg::rdc_uword_t        uword;
	logic                       take;

	assign uword = rdc_pkg::ucode_rom(step_q);
	assign op    = uword.op;

	always_comb begin
		case (uword.cond)
			rdc_pkg::COND_NEVER:       take = 1'b0;
			rdc_pkg::COND_ALWAYS:      take = 1'b1;
			rdc_pkg::COND_NO_INPUT:    take = !status.in_valid;
			rdc_pkg::COND_BAD_BASE:    take = status.bad_base;
			rdc_pkg::COND_DIV_MORE:    take = status.div_more;
			rdc_pkg::COND_MORE_DIGITS: take = status.more_digits;
			rdc_pkg::COND_OUT_BUSY:    take = status.out_busy;
			rdc_pkg::COND_CNT_NZ:      take = status.cnt_nz;
			default:                   take = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= rdc_pkg::STEP_LOAD;
		end else if (take) begin
			step_q <= uword.target;
		end else begin
			step_q <= step_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/rdc_dpath.sv
// Datapath: bit-serial divider, digit store, digit counter and output register.
`default_nettype none

module rdc_dpath #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rdc_pkg::rdc_op_t                  op,
	input  wire logic                              in_valid,
	input  wire logic [VALUE_WIDTH-1:0]            in_value,
	input  wire logic [rdc_pkg::BASE_W-1:0]        in_base,
	input  wire logic                              lower_case_first,
	input  wire logic                              out_ready,
	output      logic                              out_valid,
	output      logic [rdc_pkg::CHAR_W-1:0]        out_char,
	output      logic                              out_last,
	output      logic                              out_error,
	output      rdc_pkg::rdc_status_t              status
);

	localparam int AW  = $clog2(MAX_DIGITS);
	localparam int CW  = $clog2(MAX_DIGITS + 1);
	localparam int BCW = $clog2(VALUE_WIDTH);
	localparam int DW  = rdc_pkg::DIGIT_W;

	logic [VALUE_WIDTH-1:0]     q_q;
	logic [DW-1:0]              r_q;
	logic [rdc_pkg::BASE_W-1:0] base_q;
	logic [BCW-1:0]             bit_q;
	logic [CW-1:0]              cnt_q;

	logic [DW:0]   r_shift;
	logic [DW:0]   r_diff;
	logic          r_ge;
	logic [DW-1:0] r_next;
	logic          stall;
	logic          ram_we;
	logic [DW-1:0] ram_rdata;

	// One restoring division step: shift in the next dividend bit, subtract if it fits.
	assign r_shift = {r_q, q_q[VALUE_WIDTH-1]};
	assign r_ge    = r_shift >= {1'b0, base_q};
	assign r_diff  = r_shift - {1'b0, base_q};
	assign r_next  = r_ge ? r_diff[DW-1:0] : r_shift[DW-1:0];

	assign stall  = out_valid && !out_ready;
	assign ram_we = (op == rdc_pkg::OP_STORE);

	assign status.in_valid    = in_valid;
	assign status.bad_base    = (base_q < rdc_pkg::BASE_MIN) || (base_q > rdc_pkg::BASE_MAX);
	assign status.div_more    = bit_q != BCW'(VALUE_WIDTH - 1);
	assign status.more_digits = (q_q != '0) && (cnt_q < CW'(MAX_DIGITS - 1));
	assign status.out_busy    = stall;
	assign status.cnt_nz      = cnt_q != '0;

	rdc_ram #(
		.WIDTH (DW),
		.DEPTH (MAX_DIGITS)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_q[AW-1:0]),
		.wdata (r_q),
		.raddr (cnt_q[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_q <= '0;
			cnt_q <= '0;
		end else begin
			case (op)
				rdc_pkg::OP_LOAD: begin
					if (in_valid) begin
						bit_q <= '0;
						cnt_q <= '0;
					end
				end
				rdc_pkg::OP_DIV: begin
					bit_q <= bit_q + 1'b1;
				end
				rdc_pkg::OP_STORE: begin
					bit_q <= '0;
					cnt_q <= cnt_q + 1'b1;
				end
				rdc_pkg::OP_DEC: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			rdc_pkg::OP_LOAD: begin
				if (in_valid) begin
					q_q    <= in_value;
					base_q <= in_base;
					r_q    <= '0;
				end
			end
			rdc_pkg::OP_DIV: begin
				q_q <= {q_q[VALUE_WIDTH-2:0], r_ge};
				r_q <= r_next;
			end
			rdc_pkg::OP_STORE: begin
				r_q <= '0;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if ((op == rdc_pkg::OP_EMIT || op == rdc_pkg::OP_ERR) && !stall) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (op == rdc_pkg::OP_EMIT && !stall) begin
			out_char  <= rdc_pkg::digit_to_ascii(ram_rdata, lower_case_first);
			out_last  <= cnt_q == '0;
			out_error <= 1'b0;
		end else if (op == rdc_pkg::OP_ERR && !stall) begin
			out_char  <= '0;
			out_last  <= 1'b1;
			out_error <= 1'b1;
		end
	end

endmodule

`default_nettype wire

### rtl/radix_digit_converter.sv
// Each digit costs one pass of the bit-serial divider, one dividend bit per cycle, and a store
// of the remainder; the digits are then emitted, waiting while the output is held back. A new
// word is taken only once the previous word's digits have all been passed to the output register.
// A word with a bad base yields one error word.
// Reset (arst_n low, asynchronous) returns the sequencer to its wait step, empties the output
// register and clears the letter order; the digit store keeps its contents.
`default_nettype none

`include "assert_macros.svh"

module radix_digit_converter #(
	parameter int VALUE_WIDTH = rdc_pkg::VALUE_WIDTH_DEF,
	parameter int MAX_DIGITS  = rdc_pkg::MAX_DIGITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,

	input  wire logic                          cfg_wen,
	input  wire logic                          cfg_wdata,   // lower_case_first

	input  wire logic                          s_tvalid,
	output      logic                          s_tready,
	// [63:0] value, [69:64] base, [71:70] zero
	input  wire logic [rdc_pkg::S_TDATA_W-1:0] s_tdata,

	output      logic                          m_tvalid,
	input  wire logic                          m_tready,
	// [7:0] digit_char
	output      logic [rdc_pkg::M_TDATA_W-1:0] m_tdata,
	output      logic                          m_tlast,
	// [0] error
	output      logic                          m_tuser
);

	// The letter order register. The user must write it only while the converter is idle (the block
	// does not enforce this), so the datapath reads it directly when it forms each character.
	logic lower_case_first_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lower_case_first_q <= 1'b0;
		end else if (cfg_wen) begin
			lower_case_first_q <= cfg_wdata;
		end
	end

	rdc_pkg::rdc_op_t     op;
	rdc_pkg::rdc_status_t status;
	logic [rdc_pkg::CHAR_W-1:0] out_char;

	// Input words are taken only in the program's load step. The output register
	// is separate, so a new word can be accepted while the final digit of the
	// previous one still waits on the master side.
	assign s_tready = (op == rdc_pkg::OP_LOAD);

	// The sequencer walks the control program: load, a base check that may branch to the error
	// step, a divide loop of one step per dividend bit and a store of the remainder for each
	// digit, then a read-out loop that walks the digit store from the most significant digit down.
	rdc_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	// The datapath holds the running quotient and remainder, the digit store and
	// its fill count, and the output register.
	rdc_dpath #(
		.VALUE_WIDTH (VALUE_WIDTH),
		.MAX_DIGITS  (MAX_DIGITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.op               (op),
		.in_valid         (s_tvalid),
		.in_value         (s_tdata[VALUE_WIDTH-1:0]),
		.in_base          (s_tdata[rdc_pkg::VALUE_W +: rdc_pkg::BASE_W]),
		.lower_case_first (lower_case_first_q),
		.out_ready        (m_tready),
		.out_valid        (m_tvalid),
		.out_char         (out_char),
		.out_last         (m_tlast),
		.out_error        (m_tuser),
		.status           (status)
	);

	assign m_tdata = out_char;

	// An error word carries no character and closes its conversion.
	`RDC_ASSERT_IMPLY(a_err_word, clk, arst_n, m_tvalid && m_tuser, m_tlast && m_tdata == '0, "error word malformed")
	// A digit word is always a printable character, never NUL.
	`RDC_ASSERT_IMPLY(a_digit_char, clk, arst_n, m_tvalid && !m_tuser, m_tdata != '0, "digit word holds NUL")
	// After taking a word the sequencer leaves the load step.
	`RDC_ASSERT_NEXT(a_one_load, clk, arst_n, s_tvalid && s_tready, !s_tready, "second word taken at once")

endmodule

`default_nettype wire
